// File: rtl/core/dnv_pkg.sv
// shared types and constants of the domain name validator
package dnv_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned TotW   = 8;
  localparam int unsigned LblW   = 6;
  localparam int unsigned OffW   = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 16;

  localparam logic [TotW-1:0] MaxTotalRst = 8'd253;
  localparam logic [LblW-1:0] MaxLabelRst = 6'd63;

  localparam logic [CfgIdxW-1:0] CfgMaxTotal = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxLabel = 1'd1;

  localparam logic [ChW-1:0] ChStar   = 8'h2A;
  localparam logic [ChW-1:0] ChDot    = 8'h2E;
  localparam logic [ChW-1:0] ChHyphen = 8'h2D;
  localparam logic [ChW-1:0] ChUnder  = 8'h5F;
  localparam logic [ChW-1:0] ChZero   = 8'h30;
  localparam logic [ChW-1:0] ChNine   = 8'h39;
  localparam logic [ChW-1:0] ChLowA   = 8'h61;
  localparam logic [ChW-1:0] ChLowZ   = 8'h7A;
  localparam logic [ChW-1:0] ChUpA    = 8'h41;
  localparam logic [ChW-1:0] ChUpZ    = 8'h5A;

  localparam logic [OffW-1:0] OffWild = 2'd2;
  localparam logic [OffW-1:0] OffNone = 2'd0;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_STAR  = 2'd1,
    PH_BODY  = 2'd2,
    PH_WILD  = 2'd3
  } dnv_phase_e;

  typedef struct packed {
    dnv_phase_e      phase;
    logic [TotW-1:0] body_count;
    logic [LblW-1:0] label_count;
    logic            prev_hyphen;
    logic            seen_letter;
    logic            failed;
  } dnv_state_t;

  typedef struct packed {
    logic            trailing_dot;
    logic [TotW-1:0] name_length;
    logic [OffW-1:0] start_offset;
    logic            valid_res;
  } dnv_result_t;

endpackage

// File: rtl/core/dnv_step.sv
// per-character state update and verdict logic
module dnv_step (
  input  logic [dnv_pkg::ChW-1:0]  ch_i,
  input  logic                     last_i,
  input  dnv_pkg::dnv_state_t      st_i,
  input  logic [dnv_pkg::TotW-1:0] max_total_i,
  input  logic [dnv_pkg::LblW-1:0] max_label_i,
  output dnv_pkg::dnv_state_t      st_o,
  output dnv_pkg::dnv_result_t     res_o
);
  import dnv_pkg::*;

  logic       is_star, is_dot, is_hyphen, is_letter, is_other;
  logic       body;
  dnv_phase_e phase_d;

  assign is_star   = (ch_i == ChStar);
  assign is_dot    = (ch_i == ChDot);
  assign is_hyphen = (ch_i == ChHyphen);
  assign is_letter = ((ch_i >= ChLowA) && (ch_i <= ChLowZ)) ||
                     ((ch_i >= ChUpA) && (ch_i <= ChUpZ));
  assign is_other  = ((ch_i >= ChZero) && (ch_i <= ChNine)) || is_hyphen ||
                     (ch_i == ChUnder);

  // prefix tracking
  always_comb begin
    phase_d = st_i.phase;
    body    = 1'b1;
    unique case (st_i.phase)
      PH_START: begin
        if (is_star) begin
          phase_d = PH_STAR;
          body    = 1'b0;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_STAR: begin
        if (is_dot) begin
          phase_d = PH_WILD;
          body    = 1'b0;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY, PH_WILD: begin
        phase_d = st_i.phase;
      end
      default: begin
        phase_d = st_i.phase;
      end
    endcase
  end

  // body character, counters and verdict
  always_comb begin
    dnv_state_t nx;
    logic       tdot;
    logic       ok;
    nx       = st_i;
    nx.phase = phase_d;
    tdot     = 1'b0;
    ok       = 1'b0;
    // a star not followed by a dot is an illegal body character
    if ((st_i.phase == PH_STAR) && !is_dot) begin
      nx.failed = 1'b1;
    end
    if (body) begin
      if (is_dot && last_i) begin
        tdot = 1'b1;
      end else begin
        if (is_dot) begin
          if ((st_i.label_count == '0) || st_i.prev_hyphen) begin
            nx.failed = 1'b1;
          end
        end else begin
          if (is_letter) begin
            nx.seen_letter = 1'b1;
          end else if (!is_other) begin
            nx.failed = 1'b1;
          end
          if (is_hyphen && (st_i.label_count == '0)) begin
            nx.failed = 1'b1;
          end
        end
        if (st_i.body_count >= max_total_i) begin
          nx.failed = 1'b1;
        end else begin
          nx.body_count = st_i.body_count + 1'b1;
        end
        if (is_dot) begin
          nx.label_count = '0;
          nx.prev_hyphen = 1'b0;
        end else begin
          if (st_i.label_count >= max_label_i) begin
            nx.failed = 1'b1;
          end else begin
            nx.label_count = st_i.label_count + 1'b1;
          end
          nx.prev_hyphen = is_hyphen;
        end
      end
    end
    if (phase_d == PH_STAR) begin
      ok = 1'b0;
    end else begin
      ok = !nx.failed && (nx.body_count != '0) && (nx.label_count != '0) &&
           !nx.prev_hyphen && nx.seen_letter;
    end
    res_o.valid_res    = ok;
    res_o.start_offset = (ok && (phase_d == PH_WILD)) ? OffWild : OffNone;
    res_o.name_length  = ok ? nx.body_count : '0;
    res_o.trailing_dot = ok && tdot;
    if (last_i) begin
      st_o = '{phase: PH_START, body_count: '0, label_count: '0,
               prev_hyphen: 1'b0, seen_letter: 1'b0, failed: 1'b0};
    end else begin
      st_o = nx;
    end
  end

endmodule

// File: rtl/core/domain_name_validator_top.sv
// top level of the domain name validator: input stage, entry state and result register
//
// Domain name validator. Characters of one entry arrive on the s_axis channel,
// one byte per transfer in tdata, with tlast on the final byte. A leading "*."
// and one final dot are stripped, labels and total length are checked.
// On the final byte one verdict goes out on m_axis; other bytes give nothing.
// Verdict tdata from bit 0: valid_res, start_offset[1:0], name_length[7:0],
// trailing_dot, then four zero bits.
// The final byte is held in the input register and its verdict presented from the result register
// (the input register feeds the step logic straight into the result register).
// Throughput: one byte per cycle, except while a final byte waits for the result register;
// the entry counters and flags are updated as each byte is processed.
// Limits max_total (index 0) and max_label (index 1) come in on the cfg
// write port, to be written between entries.
// Reset clears the entry state and the valid flags of both pipeline registers and sets the limits
// to 253 and 63. When m_axis stalls, a pending verdict holds in the result
// register; bytes without tlast keep flowing until a further final byte
// reaches the input register, which then waits for the result register.
module domain_name_validator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dnv_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dnv_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [dnv_pkg::InTdataW-1:0]      s_axis_tdata_i,  // ch[7:0]
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // valid_res, start_offset[1:0], name_length[7:0], trailing_dot, zero pad
  output logic [dnv_pkg::OutTdataW-1:0]     m_axis_tdata_o
);
  import dnv_pkg::*;

  logic [TotW-1:0]  max_total_q;
  logic [LblW-1:0]  max_label_q;
  logic             in_vld_q;
  logic [ChW-1:0]   in_ch_q;
  logic             in_last_q;
  dnv_state_t       st_q, st_d;
  dnv_result_t      res_d;
  logic             out_vld_q;
  dnv_result_t      out_q;
  logic             out_free, proc, s_acc;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign proc            = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_vld_q || proc;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_total_q <= MaxTotalRst;
      max_label_q <= MaxLabelRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxTotal: max_total_q <= cfg_wdata_i[TotW-1:0];
        CfgMaxLabel: max_label_q <= cfg_wdata_i[LblW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_ch_q   <= s_axis_tdata_i[ChW-1:0];
      in_last_q <= s_axis_tlast_i;
    end
  end

  dnv_step u_step (
    .ch_i        (in_ch_q),
    .last_i      (in_last_q),
    .st_i        (st_q),
    .max_total_i (max_total_q),
    .max_label_i (max_label_q),
    .st_o        (st_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_START, body_count: '0, label_count: '0,
                prev_hyphen: 1'b0, seen_letter: 1'b0, failed: 1'b0};
    end else if (proc) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= proc && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutTdataW - $bits(dnv_result_t)){1'b0}}, out_q};

`ifndef SYNTHESIS
  // a rejected entry carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.valid_res) |->
      (out_q.start_offset == OffNone && out_q.name_length == '0 && !out_q.trailing_dot))
    else $error("invalid verdict with non-zero fields");

  // an accepted name is never empty and keeps within the total limit
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.valid_res) |->
      (out_q.name_length != '0 && out_q.name_length <= max_total_q))
    else $error("accepted name length out of range");

  // the entry state is cleared after a final byte is processed
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_last_q) |=>
      (st_q.phase == PH_START && st_q.body_count == '0 && st_q.label_count == '0 &&
       !st_q.failed && !st_q.seen_letter && !st_q.prev_hyphen))
    else $error("entry state not cleared after verdict");

  // a verdict is only loaded while the result register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_last_q) |-> out_free)
    else $error("verdict overwrote a pending result");
`endif

endmodule
